/* hw/rtl/obbsat_pkg.sv */
// ----------------------------------------------------------------------------
// obbsat_pkg
// shared types and helpers for the oriented-box separating axis test core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obbsat_pkg;

    localparam int COMP_BITS = 16;
    localparam int POS_BITS  = 32;
    localparam int HALF_BITS = 31;
    localparam int AXIS_BITS = 48;
    localparam int NUM_AXES  = 15;

    // item commands
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    typedef struct packed {
        logic [2:0][POS_BITS-1:0]  center;
        logic [2:0][HALF_BITS-1:0] half;
        logic [2:0][AXIS_BITS-1:0] axes;
    } box_t;

    // one queued test: reference box captured at push time plus the tested box
    typedef struct packed {
        box_t ref_box;
        box_t tst_box;
    } pair_t;

    typedef struct packed {
        logic  valid;
        pair_t pair;
    } queue_head_t;

    typedef struct packed {
        logic [1:0] count;
    } front_status_t;

    function automatic logic signed [COMP_BITS-1:0] comp(
        input logic [AXIS_BITS-1:0] ax,
        input int                   k
    );
        comp = $signed(ax[COMP_BITS*k +: COMP_BITS]);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/obbsat_front.sv */
// ----------------------------------------------------------------------------
// obbsat_front
// accepts items, keeps the reference box, queues test items for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obbsat_front (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic                                      cmd,
    input  wire logic [2:0][obbsat_pkg::POS_BITS-1:0]      center,
    input  wire logic [2:0][obbsat_pkg::HALF_BITS-1:0]     half,
    input  wire logic [2:0][obbsat_pkg::AXIS_BITS-1:0]     axes,
    output obbsat_pkg::queue_head_t                        head,
    input  wire logic                                      pop,
    output obbsat_pkg::front_status_t                      status
);

    obbsat_pkg::box_t  ref_reg;
    obbsat_pkg::box_t  in_box;
    obbsat_pkg::pair_t entry_reg [2];
    logic              rd_ptr_reg;
    logic              wr_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              accept;
    logic              push;
    logic              do_pop;

    assign in_box.center = center;
    assign in_box.half   = half;
    assign in_box.axes   = axes;

    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (cmd == obbsat_pkg::CMD_TEST);
    assign do_pop   = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.pair  = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg    <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept && (cmd == obbsat_pkg::CMD_STORE))
            begin
                ref_reg <= in_box;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].ref_box <= ref_reg;
            entry_reg[wr_ptr_reg].tst_box <= in_box;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/obbsat_back.sv */
// ----------------------------------------------------------------------------
// obbsat_back
// five-stage pipeline on all 15 separating axes, one item per unstalled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obbsat_back #(
    parameter int AXIS_FRAC_BITS = 14
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  obbsat_pkg::queue_head_t       head,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          overlap
);

    localparam int NA = obbsat_pkg::NUM_AXES;
    localparam int LW = 34;   // axis component, cross products included
    localparam int PW = 52;   // box axis dot axis, signed
    localparam int MW = 51;   // its magnitude
    localparam int LOW_W = 26;
    localparam int HIW_W = MW - LOW_W;
    localparam int DDW = 69;  // center difference dot axis, signed
    localparam int CW  = 88 + AXIS_FRAC_BITS;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic out_valid_reg;
    logic overlap_reg;

    obbsat_pkg::box_t                    r1_reg, t1_reg;
    logic signed [LW-1:0]                l1_reg [NA][3];
    logic signed [32:0]                  d1_reg [3];
    logic [5:0][obbsat_pkg::HALF_BITS-1:0] h2_reg;
    logic [MW-1:0]                       dot2_reg [NA][6];
    logic signed [DDW-1:0]               dd2_reg [NA];
    logic [obbsat_pkg::HALF_BITS+LOW_W-1:0] plo3_reg [NA][6];
    logic [obbsat_pkg::HALF_BITS+HIW_W-1:0] phi3_reg [NA][6];
    logic [DDW-2:0]                      dm3_reg [NA];
    logic [CW-1:0]                       rad4_reg [NA];
    logic [CW-1:0]                       dsh4_reg [NA];
    logic [NA-1:0]                       sep;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && head.valid;
    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= head.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // stage 1: axes and center difference
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= head.pair.ref_box;
            t1_reg <= head.pair.tst_box;
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k] <= 33'($signed(head.pair.tst_box.center[k]))
                           - 33'($signed(head.pair.ref_box.center[k]));
            end
        end
    end

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        // reference and test axis of a cross-product axis
        localparam int RI = (a >= 6) ? (a - 6) / 3 : 0;
        localparam int TJ = (a >= 6) ? (a - 6) % 3 : 0;

        logic signed [LW-1:0] l_comb [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                l_comb[k] = '0;
            end
            if (a < 3)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    l_comb[k] = LW'(obbsat_pkg::comp(head.pair.ref_box.axes[a % 3], k));
                end
            end
            else if (a < 6)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    l_comb[k] = LW'(obbsat_pkg::comp(head.pair.tst_box.axes[a % 3], k));
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    l_comb[k] =
                        LW'(obbsat_pkg::comp(head.pair.ref_box.axes[RI], (k + 1) % 3))
                      * LW'(obbsat_pkg::comp(head.pair.tst_box.axes[TJ], (k + 2) % 3))
                      - LW'(obbsat_pkg::comp(head.pair.ref_box.axes[RI], (k + 2) % 3))
                      * LW'(obbsat_pkg::comp(head.pair.tst_box.axes[TJ], (k + 1) % 3));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    l1_reg[a][k] <= l_comb[k];
                end
            end
        end

        // stage 2: projections of the six box axes and of the center difference
        logic signed [PW-1:0]  dot_comb [6];
        logic signed [DDW-1:0] dd_comb;

        always_comb
        begin
            for (int b = 0; b < 6; b++)
            begin
                dot_comb[b] = '0;
                for (int k = 0; k < 3; k++)
                begin
                    dot_comb[b] = dot_comb[b] + PW'(
                        (b < 3) ? obbsat_pkg::comp(r1_reg.axes[b % 3], k)
                                : obbsat_pkg::comp(t1_reg.axes[b % 3], k)) * PW'(l1_reg[a][k]);
                end
            end
            dd_comb = '0;
            for (int k = 0; k < 3; k++)
            begin
                dd_comb = dd_comb + DDW'(d1_reg[k]) * DDW'(l1_reg[a][k]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int b = 0; b < 6; b++)
                begin
                    dot2_reg[a][b] <= MW'(dot_comb[b][PW-1] ? -dot_comb[b] : dot_comb[b]);
                end
                dd2_reg[a] <= dd_comb;
            end
        end

        // stage 3: half extent times projection, split into two partial products
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int b = 0; b < 6; b++)
                begin
                    plo3_reg[a][b] <= (obbsat_pkg::HALF_BITS + LOW_W)'(h2_reg[b])
                                    * (obbsat_pkg::HALF_BITS + LOW_W)'(dot2_reg[a][b][LOW_W-1:0]);
                    phi3_reg[a][b] <= (obbsat_pkg::HALF_BITS + HIW_W)'(h2_reg[b])
                                    * (obbsat_pkg::HALF_BITS + HIW_W)'(dot2_reg[a][b][MW-1:LOW_W]);
                end
                dm3_reg[a] <= (DDW - 1)'(dd2_reg[a][DDW-1] ? -dd2_reg[a] : dd2_reg[a]);
            end
        end

        // stage 4: radius sum and scaled distance
        logic [CW-1:0] rad_comb;

        always_comb
        begin
            rad_comb = '0;
            for (int b = 0; b < 6; b++)
            begin
                rad_comb = rad_comb + CW'(plo3_reg[a][b]) + (CW'(phi3_reg[a][b]) << LOW_W);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad4_reg[a] <= rad_comb;
                dsh4_reg[a] <= CW'(dm3_reg[a]) << AXIS_FRAC_BITS;
            end
        end

        assign sep[a] = dsh4_reg[a] > rad4_reg[a];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 6; b++)
            begin
                h2_reg[b] <= (b < 3) ? r1_reg.half[b % 3] : t1_reg.half[b % 3];
            end
            overlap_reg <= ~|sep;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/obb_separating_axis_test_core.sv */
// ----------------------------------------------------------------------------
// obb_separating_axis_test_core
// oriented box overlap test against a stored reference box, 15 axes
// ----------------------------------------------------------------------------
// result path: a test item's flag passes through the queue entry, the four pipeline
// stages and the output register; store items give no result
// throughput: one item per unstalled cycle, set by the fully unrolled axis pipeline
// a two-entry queue parts the front from the pipeline; the pipeline holds as
// a whole while the output flag waits
// reset: rst_n clears the reference box to zero, the queue and all valids
`timescale 1ns / 1ps
`default_nettype none

module obb_separating_axis_test_core #(
    parameter int AXIS_FRAC_BITS = 14
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic                                    cmd,
    input  wire logic [obbsat_pkg::POS_BITS-1:0]         center_x,
    input  wire logic [obbsat_pkg::POS_BITS-1:0]         center_y,
    input  wire logic [obbsat_pkg::POS_BITS-1:0]         center_z,
    input  wire logic [obbsat_pkg::HALF_BITS-1:0]        half_x,
    input  wire logic [obbsat_pkg::HALF_BITS-1:0]        half_y,
    input  wire logic [obbsat_pkg::HALF_BITS-1:0]        half_z,
    input  wire logic [obbsat_pkg::AXIS_BITS-1:0]        axis_col0,
    input  wire logic [obbsat_pkg::AXIS_BITS-1:0]        axis_col1,
    input  wire logic [obbsat_pkg::AXIS_BITS-1:0]        axis_col2,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic                                         overlap
);

    obbsat_pkg::queue_head_t   head;
    obbsat_pkg::front_status_t status;
    logic                      pop;

    obbsat_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .center   ({center_z, center_y, center_x}),
        .half     ({half_z, half_y, half_x}),
        .axes     ({axis_col2, axis_col1, axis_col0}),
        .head     (head),
        .pop      (pop),
        .status   (status)
    );

    obbsat_back #(
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .overlap   (overlap)
    );

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(overlap))
        else $error("result changed while stalled");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count != 2'd3)
        else $error("queue count out of range");

    a_store_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == obbsat_pkg::CMD_STORE)
        |=> status.count <= $past(status.count))
        else $error("store item entered the queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        status.count == 2'd0 && !(in_valid && (cmd == obbsat_pkg::CMD_TEST))
        |=> status.count == 2'd0)
        else $error("queue filled without a test item");
`endif

endmodule

`default_nettype wire
